[src/rdf_pkg.sv]
package rdf_pkg;

	// fixed geometry
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CODE_BYTES      = 4;
	localparam int APB_AW          = 3;

	// payload widths
	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;
	localparam int SIZE_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int EV_W    = 3;
	localparam int CODE_W  = 32;
	localparam int SPEC_W  = KIND_W + SIZE_W;
	localparam int BCNT_W  = 2;

	// operations
	localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

	// response kinds
	localparam logic [KIND_W-1:0] KIND_CODE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIXED = 2'd1;

	// events
	localparam logic [EV_W-1:0] EV_BODY   = 3'd0;
	localparam logic [EV_W-1:0] EV_DONE   = 3'd1;
	localparam logic [EV_W-1:0] EV_FAIL   = 3'd2;
	localparam logic [EV_W-1:0] EV_REJECT = 3'd3;
	localparam logic [EV_W-1:0] EV_CLOSE  = 3'd4;

	// register indexes and reset values
	localparam logic REG_FINISH  = 1'b0;
	localparam logic REG_FAILURE = 1'b1;
	localparam logic [CODE_W-1:0] FINISH_RST  = 32'd200;
	localparam logic [CODE_W-1:0] FAILURE_RST = 32'd503;

	typedef struct packed {
		logic [CODE_W-1:0] finish_code;
		logic [CODE_W-1:0] failure_code;
	} cfg_t;

	typedef struct packed {
		logic [EV_W-1:0]   event_res;
		logic [CODE_W-1:0] resp_code;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} evt_t;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_SIZE,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DRAIN
	} state_t;

endpackage

[src/rdf_if.sv]
interface rdf_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [rdf_pkg::OP_W-1:0]     operation;
	logic [rdf_pkg::KIND_W-1:0]   resp_kind;
	logic [rdf_pkg::SIZE_W-1:0]   fixed_size;
	logic [rdf_pkg::BYTE_W-1:0]   rx_byte;

	modport source(output valid, operation, resp_kind, fixed_size, rx_byte, input ready);
	modport sink(input valid, operation, resp_kind, fixed_size, rx_byte, output ready);
endinterface

interface rdf_evt_if;
	logic                         valid;
	logic                         ready;
	logic [rdf_pkg::EV_W-1:0]     event_res;
	logic [rdf_pkg::CODE_W-1:0]   resp_code;
	logic [rdf_pkg::BYTE_W-1:0]   data_byte;
	logic                         last;

	modport source(output valid, event_res, resp_code, data_byte, last, input ready);
	modport sink(input valid, event_res, resp_code, data_byte, last, output ready);
endinterface

[src/rdf_ram.sv]
module rdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/rdf_cfg.sv]
module rdf_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rdf_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output rdf_pkg::cfg_t                cfg
);

	rdf_pkg::cfg_t cfg_q;
	logic          wr_en;

	// word index is paddr[2]; low bits ignored
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign prdata = (paddr[2] == rdf_pkg::REG_FAILURE) ? cfg_q.failure_code : cfg_q.finish_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finish_code  <= rdf_pkg::FINISH_RST;
			cfg_q.failure_code <= rdf_pkg::FAILURE_RST;
		end else if (wr_en) begin
			if (paddr[2] == rdf_pkg::REG_FAILURE) begin
				cfg_q.failure_code <= pwdata;
			end else begin
				cfg_q.finish_code <= pwdata;
			end
		end
	end

endmodule

[src/response_deframer_with_pending_queue_core.sv]
// Output: a result is registered and shows in the cycle after its item is accepted; a return
//   code that matches finish_code with a request queued first passes the lookup state for the spec read.
// Throughput: one item per cycle while the output slot is free; a finishing code holds input in the
//   spec lookup state; a close emits one failure result per cycle the slot is free, per queued request.
// Reset: arst_n clears parser, queue pointers, close flag and output valid at once; the spec
//   RAM is not cleared (entries are only read after being written), so no init pass is needed.
module response_deframer_with_pending_queue_core #(
	parameter int QUEUE_DEPTH = rdf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rdf_cmd_if.sink                      cmd,
	rdf_evt_if.source                    evt,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rdf_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	// ---------------------------------------------------------------- config
	rdf_pkg::cfg_t cfg;

	rdf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- state
	rdf_pkg::state_t                  state_q, state_d;
	rdf_pkg::phase_t                  phase_q, phase_d;
	logic [31:0]                      asm_q, asm_d;
	logic [rdf_pkg::BCNT_W-1:0]       bcnt_q, bcnt_d;
	logic [rdf_pkg::CODE_W-1:0]       saved_q, saved_d;
	logic [31:0]                      remain_q, remain_d;
	logic [IW-1:0]                    head_q, head_d;
	logic [CW-1:0]                    count_q, count_d;
	logic                             closed_q, closed_d;
	logic                             out_valid_q, out_valid_d;
	rdf_pkg::evt_t                    out_q, out_d;
	logic                             out_load;

	// spec queue RAM: {kind, size} per pending request
	logic                             ram_we;
	logic [IW-1:0]                    ram_waddr;
	logic [rdf_pkg::SPEC_W-1:0]       ram_wdata;
	logic [rdf_pkg::SPEC_W-1:0]       ram_rdata;

	// head entry is read every cycle; the lookup state sees the head as of the accept edge
	rdf_ram #(
		.WIDTH (rdf_pkg::SPEC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_spec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- decode
	logic                             out_free;
	logic                             in_fire;
	logic                             full;
	logic [SW-1:0]                    tail_sum;
	logic [IW-1:0]                    tail;
	logic [IW-1:0]                    head_inc;
	logic [31:0]                      byte_asm;
	logic                             code_done;
	logic [31:0]                      remain_dec;
	logic [rdf_pkg::KIND_W-1:0]       spec_kind;
	logic [rdf_pkg::SIZE_W-1:0]       spec_size;

	assign out_free  = !out_valid_q || evt.ready;
	assign cmd.ready = (state_q == rdf_pkg::ST_IDLE) && out_free;
	assign in_fire   = cmd.valid && cmd.ready;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                  : IW'(tail_sum);
	assign head_inc  = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// little-endian assembly of code and size words
	assign byte_asm   = asm_q | ({24'd0, cmd.rx_byte} << {bcnt_q, 3'b000});
	assign code_done  = (bcnt_q == rdf_pkg::BCNT_W'(rdf_pkg::CODE_BYTES - 1));
	assign remain_dec = remain_q - {31'd0, (remain_q != 32'd0)};

	assign spec_kind = ram_rdata[rdf_pkg::SPEC_W-1:rdf_pkg::SIZE_W];
	assign spec_size = ram_rdata[rdf_pkg::SIZE_W-1:0];

	assign ram_waddr = tail;
	assign ram_wdata = {cmd.resp_kind, cmd.fixed_size};

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdf_pkg::ST_IDLE: begin
				if (in_fire && !closed_q) begin
					if (cmd.operation == rdf_pkg::OP_CLOSE && count_q != '0) begin
						state_d = rdf_pkg::ST_DRAIN;
					end else if (cmd.operation == rdf_pkg::OP_BYTE
					             && phase_q == rdf_pkg::PH_CODE && code_done
					             && count_q != '0 && byte_asm == cfg.finish_code) begin
						state_d = rdf_pkg::ST_LOOKUP;
					end
				end
			end
			rdf_pkg::ST_LOOKUP: begin
				state_d = rdf_pkg::ST_IDLE;
			end
			rdf_pkg::ST_DRAIN: begin
				if (out_free && count_q == CW'(1)) begin
					state_d = rdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdf_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- datapath / outputs
	always_comb begin
		phase_d  = phase_q;
		asm_d    = asm_q;
		bcnt_d   = bcnt_q;
		saved_d  = saved_q;
		remain_d = remain_q;
		head_d   = head_q;
		count_d  = count_q;
		closed_d = closed_q;
		ram_we   = 1'b0;
		out_load = 1'b0;
		out_d    = out_q;

		case (state_q)
			rdf_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (cmd.operation)
						rdf_pkg::OP_ENQ: begin
							if (closed_q || full) begin
								out_load = 1'b1;
								out_d    = '{rdf_pkg::EV_REJECT, '0, '0, 1'b1};
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						rdf_pkg::OP_BYTE: begin
							if (!closed_q) begin
								if (phase_q == rdf_pkg::PH_BODY) begin
									// body byte streams straight out
									remain_d = remain_dec;
									out_load = 1'b1;
									out_d    = '{rdf_pkg::EV_BODY, saved_q, cmd.rx_byte,
									             (remain_dec == 32'd0)};
									if (remain_dec == 32'd0) begin
										phase_d = rdf_pkg::PH_CODE;
										bcnt_d  = '0;
										if (count_q != '0) begin
											head_d  = head_inc;
											count_d = count_q - 1'b1;
										end
									end
								end else if (!code_done) begin
									asm_d  = byte_asm;
									bcnt_d = bcnt_q + 1'b1;
								end else begin
									asm_d  = '0;
									bcnt_d = '0;
									if (phase_q == rdf_pkg::PH_SIZE) begin
										if (byte_asm == 32'd0) begin
											// zero size: done, no body
											phase_d  = rdf_pkg::PH_CODE;
											out_load = 1'b1;
											out_d    = '{rdf_pkg::EV_DONE, saved_q, '0, 1'b1};
											if (count_q != '0) begin
												head_d  = head_inc;
												count_d = count_q - 1'b1;
											end
										end else begin
											remain_d = byte_asm;
											phase_d  = rdf_pkg::PH_BODY;
										end
									end else if (count_q == '0) begin
										// unsolicited response: protocol violation
										closed_d = 1'b1;
										out_load = 1'b1;
										out_d    = '{rdf_pkg::EV_CLOSE, byte_asm, '0, 1'b1};
									end else begin
										saved_d = byte_asm;
										if (byte_asm != cfg.finish_code) begin
											// error code completes the request
											out_load = 1'b1;
											out_d    = '{rdf_pkg::EV_DONE, byte_asm, '0, 1'b1};
											head_d   = head_inc;
											count_d  = count_q - 1'b1;
										end
										// finish code: spec lookup next cycle
									end
								end
							end
						end
						rdf_pkg::OP_CLOSE: begin
							closed_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			rdf_pkg::ST_LOOKUP: begin
				// head spec is on the RAM read port now
				if (spec_kind == rdf_pkg::KIND_CODE
				    || (spec_kind == rdf_pkg::KIND_FIXED && spec_size == 32'd0)) begin
					out_load = 1'b1;
					out_d    = '{rdf_pkg::EV_DONE, saved_q, '0, 1'b1};
					head_d   = head_inc;
					count_d  = count_q - 1'b1;
				end else if (spec_kind == rdf_pkg::KIND_FIXED) begin
					remain_d = spec_size;
					phase_d  = rdf_pkg::PH_BODY;
				end else begin
					phase_d = rdf_pkg::PH_SIZE;
				end
			end
			rdf_pkg::ST_DRAIN: begin
				// fail one pending request per free output slot
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{rdf_pkg::EV_FAIL, cfg.failure_code, '0, (count_q == CW'(1))};
					head_d   = head_inc;
					count_d  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (evt.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdf_pkg::ST_IDLE;
			phase_q     <= rdf_pkg::PH_CODE;
			asm_q       <= '0;
			bcnt_q      <= '0;
			saved_q     <= '0;
			remain_q    <= '0;
			head_q      <= '0;
			count_q     <= '0;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			asm_q       <= asm_d;
			bcnt_q      <= bcnt_d;
			saved_q     <= saved_d;
			remain_q    <= remain_d;
			head_q      <= head_d;
			count_q     <= count_d;
			closed_q    <= closed_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_res   = out_q.event_res;
	assign evt.resp_code   = out_q.resp_code;
	assign evt.data_byte   = out_q.data_byte;
	assign evt.last        = out_q.last;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH         = rdf_pkg::QUEUE_DEPTH_DEF;
	localparam int IDX_W         = $clog2(DEPTH);
	localparam int SETTLE        = 4;      // settling wait after the results have drained, in cycles
	localparam int DRAIN_LIMIT   = 100000; // cycles to wait for outstanding results
	localparam int PRESSURE_HOLD = 300;    // receiver hold-off, in cycles
	localparam int PRESSURE_BODY = 24;     // body bytes offered during the hold-off

	// codes the package does not name
	localparam logic [rdf_pkg::OP_W-1:0]   OP_IDLE        = 2'd3;
	localparam logic [rdf_pkg::KIND_W-1:0] KIND_SIZED_ALT = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [rdf_pkg::APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rdf_cmd_if cmd_bus();
	rdf_evt_if evt_bus();

	response_deframer_with_pending_queue_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.evt     (evt_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predicted block state. Tracks the deframer as items are accepted.
	// ------------------------------------------------------------------
	logic [rdf_pkg::CODE_W-1:0] finish_val;   // mirrors finish_code register
	logic [rdf_pkg::CODE_W-1:0] failure_val;  // mirrors failure_code register
	rdf_pkg::phase_t            rx_phase;     // parser position within a response
	logic [rdf_pkg::CODE_W-1:0] code_acc;     // little-endian word being assembled
	logic [rdf_pkg::BCNT_W-1:0] code_cnt;     // bytes of that word seen so far
	logic [rdf_pkg::CODE_W-1:0] ok_code;      // code reported with body bytes
	logic [rdf_pkg::SIZE_W-1:0] body_left;
	logic [rdf_pkg::KIND_W-1:0] spec_kind_mem [DEPTH];
	logic [rdf_pkg::SIZE_W-1:0] spec_size_mem [DEPTH];
	int unsigned                q_head;
	int unsigned                q_count;
	bit                         is_closed;

	rdf_pkg::evt_t due_events[$];  // results predicted but not yet seen, oldest first

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned cfg_writes;
	int unsigned errors;
	string       ending_desc;

	// stimulus shaping
	bit          tx_calm;   // sender never idles while set
	bit          rx_calm;   // receiver never stalls while set
	int unsigned hold_req;  // long hold-off request, picked up by the receiver
	int unsigned hold_left;
	int unsigned stall_left;

	function automatic void push_event(logic [rdf_pkg::EV_W-1:0] ev,
			logic [rdf_pkg::CODE_W-1:0] code, logic [rdf_pkg::BYTE_W-1:0] data, logic fin);
		rdf_pkg::evt_t e;
		e.event_res = ev;
		e.resp_code = code;
		e.data_byte = data;
		e.last      = fin;
		due_events  = {due_events, e};
	endfunction

	function automatic void retire_front();
		if (q_count != 0) begin
			q_head  = (q_head + 1) % DEPTH;
			q_count = q_count - 1;
		end
	endfunction

	// front request finishes without a body
	function automatic void complete_nobody(logic [rdf_pkg::CODE_W-1:0] code);
		retire_front();
		rx_phase = rdf_pkg::PH_CODE;
		code_cnt = '0;
		push_event(rdf_pkg::EV_DONE, code, '0, 1'b1);
	endfunction

	function automatic void parse_byte(logic [rdf_pkg::BYTE_W-1:0] b);
		logic [rdf_pkg::CODE_W-1:0] word;
		if (rx_phase == rdf_pkg::PH_BODY) begin
			if (body_left != 0)
				body_left = body_left - 1;
			if (body_left == 0) begin
				retire_front();
				rx_phase = rdf_pkg::PH_CODE;
				code_cnt = '0;
				push_event(rdf_pkg::EV_BODY, ok_code, b, 1'b1);
			end else begin
				push_event(rdf_pkg::EV_BODY, ok_code, b, 1'b0);
			end
			return;
		end
		// code and size words both come in little-endian
		code_acc = code_acc | (rdf_pkg::CODE_W'(b) << (8 * code_cnt));
		code_cnt = code_cnt + 1'b1;
		if (code_cnt != 0)
			return;
		word     = code_acc;
		code_acc = '0;
		if (rx_phase == rdf_pkg::PH_SIZE) begin
			if (word == 0) begin
				complete_nobody(ok_code);
			end else begin
				body_left = word;
				rx_phase  = rdf_pkg::PH_BODY;
			end
			return;
		end
		// a code with no request waiting is a protocol violation: close for good
		if (q_count == 0) begin
			is_closed = 1'b1;
			push_event(rdf_pkg::EV_CLOSE, word, '0, 1'b1);
			return;
		end
		ok_code = word;
		if (word != finish_val) begin
			complete_nobody(word);
			return;
		end
		case (spec_kind_mem[IDX_W'(q_head)])
			rdf_pkg::KIND_CODE: begin
				complete_nobody(word);
			end
			rdf_pkg::KIND_FIXED: begin
				if (spec_size_mem[IDX_W'(q_head)] == 0) begin
					complete_nobody(word);
				end else begin
					body_left = spec_size_mem[IDX_W'(q_head)];
					rx_phase  = rdf_pkg::PH_BODY;
				end
			end
			default: begin
				// size-prefixed, kind three included
				rx_phase = rdf_pkg::PH_SIZE;
			end
		endcase
	endfunction

	// predicts the results of one accepted item
	function automatic void deframe_item(logic [rdf_pkg::OP_W-1:0] op,
			logic [rdf_pkg::KIND_W-1:0] kind, logic [rdf_pkg::SIZE_W-1:0] size,
			logic [rdf_pkg::BYTE_W-1:0] b);
		int unsigned slot;
		case (op)
			rdf_pkg::OP_ENQ: begin
				if (is_closed || q_count >= DEPTH) begin
					push_event(rdf_pkg::EV_REJECT, '0, '0, 1'b1);
				end else begin
					slot = (q_head + q_count) % DEPTH;
					spec_kind_mem[IDX_W'(slot)] = kind;
					spec_size_mem[IDX_W'(slot)] = size;
					q_count = q_count + 1;
				end
			end
			rdf_pkg::OP_BYTE: begin
				if (!is_closed)
					parse_byte(b);
			end
			rdf_pkg::OP_CLOSE: begin
				if (!is_closed) begin
					is_closed = 1'b1;
					while (q_count != 0) begin
						q_count = q_count - 1;
						q_head  = (q_head + 1) % DEPTH;
						push_event(rdf_pkg::EV_FAIL, failure_val, '0, q_count == 0);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [rdf_pkg::SIZE_W-1:0] pick_body_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 95)
			return $urandom_range(1, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [rdf_pkg::CODE_W-1:0] error_code();
		logic [rdf_pkg::CODE_W-1:0] c;
		c = $urandom;
		if (c == finish_val)
			c = ~c;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random ready, plus the long hold-off on request.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_bus.ready = 1'b0;
		end else begin
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				evt_bus.ready = 1'b0;
				hold_left = hold_left - 1;
			end else if (stall_left != 0) begin
				evt_bus.ready = 1'b0;
				stall_left = stall_left - 1;
			end else begin
				evt_bus.ready = 1'b1;
				stall_left = pick_gap(rx_calm);
			end
		end
	end

	// Each accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : check_result
		rdf_pkg::evt_t got;
		rdf_pkg::evt_t want;
		if (arst_n && evt_bus.valid && evt_bus.ready) begin
			got.event_res = evt_bus.event_res;
			got.resp_code = evt_bus.resp_code;
			got.data_byte = evt_bus.data_byte;
			got.last      = evt_bus.last;
			results_seen = results_seen + 1;
			if (due_events.size() == 0) begin
				errors = errors + 1;
				$display({"%0t ns: mismatch expected no result,",
					" got ev=%0d code=%h data=%h last=%b"},
					$time, got.event_res, got.resp_code, got.data_byte, got.last);
			end else begin
				want = due_events[0];
				due_events.delete(0);
				if (got.event_res !== want.event_res || got.resp_code !== want.resp_code ||
						got.data_byte !== want.data_byte || got.last !== want.last) begin
					errors = errors + 1;
					$display({"%0t ns: mismatch expected ev=%0d code=%h data=%h last=%b,",
						" got ev=%0d code=%h data=%h last=%b"}, $time,
						want.event_res, want.resp_code, want.data_byte, want.last,
						got.event_res, got.resp_code, got.data_byte, got.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Item and register traffic
	// ------------------------------------------------------------------

	// Offers one item, holds it until taken, predicts it, then maybe idles.
	task automatic send_item(logic [rdf_pkg::OP_W-1:0] op, logic [rdf_pkg::KIND_W-1:0] kind,
			logic [rdf_pkg::SIZE_W-1:0] size, logic [rdf_pkg::BYTE_W-1:0] b);
		int unsigned gap;
		@(negedge clk);
		cmd_bus.valid      = 1'b1;
		cmd_bus.operation  = op;
		cmd_bus.resp_kind  = kind;
		cmd_bus.fixed_size = size;
		cmd_bus.rx_byte    = b;
		do @(posedge clk); while (!cmd_bus.ready);
		// items the block just drops are not counted
		if (op != OP_IDLE && (op == rdf_pkg::OP_ENQ || !is_closed))
			items_sent = items_sent + 1;
		deframe_item(op, kind, size, b);
		gap = pick_gap(tx_calm);
		if (gap != 0) begin
			@(negedge clk);
			cmd_bus.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_byte(logic [rdf_pkg::BYTE_W-1:0] b);
		send_item(rdf_pkg::OP_BYTE, rdf_pkg::KIND_W'($urandom_range(0, 3)), $urandom, b);
	endtask

	task automatic send_word(logic [rdf_pkg::CODE_W-1:0] w);
		for (int i = 0; i < rdf_pkg::CODE_BYTES; i++)
			send_byte(w[8*i +: 8]);
	endtask

	task automatic enqueue_random();
		logic [rdf_pkg::KIND_W-1:0] kind;
		logic [rdf_pkg::SIZE_W-1:0] size;
		int unsigned r;
		kind = rdf_pkg::KIND_W'($urandom_range(0, 3));
		r    = $urandom_range(0, 99);
		if (kind != rdf_pkg::KIND_FIXED || r < 10)
			size = $urandom;   // fixed sizes over 40 only ever meet an error code; other kinds ignore size
		else if (r < 25)
			size = '0;
		else
			size = pick_body_len();
		send_item(rdf_pkg::OP_ENQ, kind, size, rdf_pkg::BYTE_W'($urandom));
	endtask

	// body bytes, with the odd enqueue slipped in between them
	task automatic stream_body(logic [rdf_pkg::SIZE_W-1:0] n);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0 && q_count < DEPTH)
				enqueue_random();
			send_byte(rdf_pkg::BYTE_W'($urandom));
		end
	endtask

	// One complete, well-formed response to the front request.
	task automatic answer_front();
		logic [rdf_pkg::KIND_W-1:0] kind;
		logic [rdf_pkg::SIZE_W-1:0] size;
		logic [rdf_pkg::SIZE_W-1:0] len;
		bit                         go_ok;
		kind  = spec_kind_mem[IDX_W'(q_head)];
		size  = spec_size_mem[IDX_W'(q_head)];
		go_ok = ($urandom_range(0, 2) != 0) && !(kind == rdf_pkg::KIND_FIXED && size > 40);
		send_word(go_ok ? finish_val : error_code());
		if (go_ok && kind == rdf_pkg::KIND_FIXED) begin
			stream_body(size);
		end else if (go_ok && kind != rdf_pkg::KIND_CODE) begin
			len = pick_body_len();
			send_word(len);
			stream_body(len);
		end
	endtask

	// Sender pauses until every predicted result is back, then waits out SETTLE.
	task automatic wait_drain();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		while (due_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited = waited + 1;
		end
		if (due_events.size() != 0) begin
			errors = errors + 1;
			$display("%0t ns: %0d expected results never arrived", $time, due_events.size());
			due_events.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == rdf_pkg::REG_FINISH)
			finish_val = data;
		else
			failure_val = data;
		cfg_writes = cfg_writes + 1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// registers only change once every predicted result is back
	task automatic set_regs(logic [rdf_pkg::CODE_W-1:0] finish,
			logic [rdf_pkg::CODE_W-1:0] failure);
		wait_drain();
		apb_write(rdf_pkg::REG_FINISH, finish);
		apb_write(rdf_pkg::REG_FAILURE, failure);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes and the corner cases, at reset register values.
	task automatic test_directed();
		send_item(rdf_pkg::OP_ENQ, rdf_pkg::KIND_CODE, '0, '0);
		send_item(rdf_pkg::OP_ENQ, rdf_pkg::KIND_FIXED, 32'd2, 8'h00);
		send_item(rdf_pkg::OP_ENQ, KIND_SIZED_ALT, '1, '1);  // kind three acts size-prefixed
		send_item(OP_IDLE, KIND_SIZED_ALT, '1, '1);          // unused operation: dropped
		send_word('1);                                       // error code, no body
		send_word(finish_val);                               // fixed body of two bytes
		send_byte(8'h00);
		send_byte(8'hFF);
		send_word(finish_val);                               // zero size prefix: no body
		send_word('0);
	endtask

	// Mostly well-formed request/response traffic with some noise mixed in.
	task automatic test_random_traffic(int unsigned n);
		int unsigned start;
		int unsigned r;
		start = items_sent;
		while (items_sent - start < n) begin
			r = $urandom_range(0, 99);
			if (q_count == 0 || r < 30) begin
				enqueue_random();             // rejected once the queue is full
			end else if (r < 35) begin
				send_item(OP_IDLE, rdf_pkg::KIND_W'($urandom), $urandom,
					rdf_pkg::BYTE_W'($urandom));
			end else if (r < 38) begin
				while (q_count < DEPTH)
					enqueue_random();
				enqueue_random();
			end else begin
				answer_front();
			end
		end
	endtask

	// Result side held off while a long body is pushed in, so the block backs up.
	task automatic test_backpressure();
		while (q_count != 0)
			answer_front();
		send_item(rdf_pkg::OP_ENQ, rdf_pkg::KIND_FIXED, PRESSURE_BODY,
			rdf_pkg::BYTE_W'($urandom));
		hold_req = PRESSURE_HOLD;
		tx_calm  = 1'b1;
		send_word(finish_val);
		for (int i = 0; i < PRESSURE_BODY; i++)
			send_byte(rdf_pkg::BYTE_W'($urandom));
		tx_calm = 1'b0;
		wait_drain();
	endtask

	// Closing is permanent short of reset, so it comes last and one way only.
	task automatic test_close_ending();
		logic [rdf_pkg::CODE_W-1:0] fail_pick;
		case ($urandom_range(0, 2))
			0: fail_pick = '0;
			1: fail_pick = '1;
			default: fail_pick = $urandom;
		endcase
		set_regs($urandom, fail_pick);
		if ($urandom_range(0, 1) == 1) begin
			ending_desc = "explicit close of a full queue";
			while (q_count < DEPTH)
				enqueue_random();
			enqueue_random();
			send_item(rdf_pkg::OP_CLOSE, rdf_pkg::KIND_W'($urandom), $urandom,
				rdf_pkg::BYTE_W'($urandom));
		end else begin
			ending_desc = "return code with no request pending";
			while (q_count != 0)
				answer_front();
			send_word($urandom);
			// already closed
			send_item(rdf_pkg::OP_CLOSE, rdf_pkg::KIND_W'($urandom), $urandom,
				rdf_pkg::BYTE_W'($urandom));
		end
		// once closed: enqueue rejected, bytes and close dropped
		enqueue_random();
		send_word($urandom);
		send_item(rdf_pkg::OP_CLOSE, rdf_pkg::KIND_W'($urandom), $urandom,
			rdf_pkg::BYTE_W'($urandom));
		send_item(OP_IDLE, rdf_pkg::KIND_W'($urandom), $urandom, rdf_pkg::BYTE_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.operation  = rdf_pkg::OP_ENQ;
		cmd_bus.resp_kind  = rdf_pkg::KIND_CODE;
		cmd_bus.fixed_size = '0;
		cmd_bus.rx_byte    = '0;
		evt_bus.ready      = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;

		finish_val   = rdf_pkg::FINISH_RST;
		failure_val  = rdf_pkg::FAILURE_RST;
		rx_phase     = rdf_pkg::PH_CODE;
		code_acc     = '0;
		code_cnt     = '0;
		ok_code      = '0;
		body_left    = '0;
		q_head       = 0;
		q_count      = 0;
		is_closed    = 1'b0;
		items_sent   = 0;
		results_seen = 0;
		cfg_writes   = 0;
		errors       = 0;
		tx_calm      = 1'b0;
		rx_calm      = 1'b0;
		hold_req     = 0;
		hold_left    = 0;
		stall_left   = 0;
		ending_desc  = "none";

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(22);

		// register extremes; this stretch runs with no idling on either side
		set_regs('0, '1);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		test_random_traffic(22);
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		set_regs('1, '0);
		test_random_traffic(22);

		set_regs($urandom, $urandom);
		test_backpressure();
		test_random_traffic(20);

		test_close_ending();
		wait_drain();

		$display("Run: %0d items, %0d results checked, %0d register writes.",
			items_sent, results_seen, cfg_writes);
		$display("Covered all kinds, body streaming, queue-full rejects, back-pressure; %s.",
			ending_desc);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, well past the slowest legal run
	initial begin
		#20_000_000;
		$display("Timeout at %0t ns", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
